@@ hdl/sgi_pkg.sv @@
// Shared types and constants for the spectral gain interpolator.
// No dependencies; imported by every module of the block.
package sgi_pkg;

  // Input command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_BIN    = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_BIN_DONE  = 3'd0;
  localparam logic [2:0] ST_STORED    = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_CLEARED   = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  // Unity gain in signed Q16.16
  localparam logic signed [31:0] GAIN_ONE = 32'sd65536;

  // Width of bin frequency (16-bit index times Q16.16 step)
  localparam int unsigned FREQ_W = 48;

  // Operation decided by the front end
  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_PASS   = 3'd2,
    OP_BIN    = 3'd3,
    OP_NOP    = 3'd4
  } op_e;

  // Classified transaction handed from front to back
  typedef struct packed {
    op_e                op;
    logic [FREQ_W-1:0]  freq;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [31:0]        pfreq;
    logic signed [31:0] pgain;
  } item_t;

endpackage

@@ hdl/sgi_front.sv @@
// Front end: accepts input transactions, classifies them, computes bin frequency.
// Depends on sgi_pkg.
module sgi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [15:0]         bin_index_i,
  input  logic signed [31:0]  bin_re_i,
  input  logic signed [31:0]  bin_im_i,
  input  logic [31:0]         point_freq_i,
  input  logic signed [31:0]  point_gain_i,
  input  logic [31:0]         freq_step_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output sgi_pkg::item_t      push_item_o
);
  import sgi_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;
  op_e   op;

  assign in_ready_o   = !valid_q || push_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  // Decode command into an operation
  always_comb begin
    case (command_i)
      CMD_CLEAR:  op = OP_CLEAR;
      CMD_APPEND: op = OP_APPEND;
      CMD_BIN:    op = (bin_index_i == 16'd0) ? OP_PASS : OP_BIN;
      default:    op = OP_NOP;
    endcase
  end

  // Stage register; the one multiply sits here
  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d      = 1'b1;
      item_d.op    = op;
      item_d.freq  = FREQ_W'(bin_index_i) * FREQ_W'(freq_step_i);
      item_d.re    = bin_re_i;
      item_d.im    = bin_im_i;
      item_d.pfreq = point_freq_i;
      item_d.pgain = point_gain_i;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

@@ hdl/sgi_queue.sv @@
// Two-entry queue decoupling front end and back end.
// Depends on sgi_pkg.
module sgi_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  sgi_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output sgi_pkg::item_t pop_item_o
);
  import sgi_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = slot_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop)      fill_q <= fill_q + 2'd1;
      else if (pop && !push) fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_item_i;
  end

endmodule

@@ hdl/sgi_back.sv @@
// Back end: breakpoint table, forward walk, serial interpolation divide, scaling.
// Depends on sgi_pkg; holds the table memory and the result register.
module sgi_back #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_o,
  input  sgi_pkg::item_t      pop_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  out_re_o,
  output logic signed [31:0]  out_im_o,
  output logic [2:0]          status_o
);
  import sgi_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_CHK0 = 12'b000000000010,
    S_CHKL = 12'b000000000100,
    S_WALK = 12'b000000001000,
    S_PREV = 12'b000000010000,
    S_MUL  = 12'b000000100000,
    S_DIV  = 12'b000001000000,
    S_ADD  = 12'b000010000000,
    S_SRE  = 12'b000100000000,
    S_SIM  = 12'b001000000000,
    S_SAT  = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // Table memory: {freq, gain} per entry, registered read
  logic [63:0]   mem_q [TABLE_DEPTH];
  logic [63:0]   rdata_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [31:0]   rd_freq;
  logic signed [31:0] rd_gain;

  // Control state
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] j_q, j_d;
  logic [5:0]    step_q, step_d;
  logic          out_valid_q, out_valid_d;

  // Datapath registers
  item_t              item_q, item_d;
  logic [31:0]        f0_q, f0_d;
  logic [31:0]        fj_q, fj_d;
  logic signed [31:0] gj_q, gj_d;
  logic signed [31:0] gbase_q, gbase_d;
  logic [31:0]        span_q, span_d;
  logic [31:0]        off_q, off_d;
  logic [32:0]        dmag_q, dmag_d;
  logic               neg_q, neg_d;
  logic [63:0]        quo_q, quo_d;
  logic [32:0]        rem_q, rem_d;
  logic signed [31:0] gain_q, gain_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] res_re_q, res_re_d;
  logic signed [31:0] res_im_q, res_im_d;
  logic               sat_q, sat_d;
  logic [2:0]         res_st_q, res_st_d;
  logic signed [31:0] out_re_q, out_re_d;
  logic signed [31:0] out_im_q, out_im_d;
  logic [2:0]         out_st_q, out_st_d;

  // Helpers
  logic [AW-1:0]      last;
  logic [FREQ_W-1:0]  f;
  logic [32:0]        trial;
  logic signed [32:0] dg;
  logic [31:0]        fdiff;
  logic signed [63:0] rnd;
  logic signed [47:0] rsh;
  logic signed [31:0] rsat;
  logic               rovf;

  assign rd_freq = rdata_q[63:32];
  assign rd_gain = rdata_q[31:0];
  assign last    = count_q[AW-1:0] - AW'(1);
  assign f       = item_q.freq;
  assign trial   = {rem_q[31:0], quo_q[63]} - {1'b0, span_q};
  assign dg      = 33'(gj_q) - 33'(rd_gain);
  assign fdiff   = f[31:0] - rd_freq;

  // Round half up and saturate the product register
  assign rnd  = prod_q + 64'sd32768;
  assign rsh  = rnd[63:16];
  assign rovf = (rsh > 48'sd2147483647) || (rsh < -48'sd2147483648);
  assign rsat = rovf ? ((rsh < 0) ? 32'sh80000000 : 32'sh7fffffff) : rsh[31:0];

  assign pop_o       = (state_q == S_IDLE) && pop_valid_i;
  assign mem_we      = pop_o && (pop_item_i.op == OP_APPEND) && (count_q < DEPTH_C);
  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign status_o    = out_st_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    wp_d        = wp_q;
    j_d         = j_q;
    step_d      = step_q;
    item_d      = item_q;
    f0_d        = f0_q;
    fj_d        = fj_q;
    gj_d        = gj_q;
    gbase_d     = gbase_q;
    span_d      = span_q;
    off_d       = off_q;
    dmag_d      = dmag_q;
    neg_d       = neg_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    gain_d      = gain_q;
    prod_d      = prod_q;
    res_re_d    = res_re_q;
    res_im_d    = res_im_q;
    sat_d       = sat_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_re_d    = out_re_q;
    out_im_d    = out_im_q;
    out_st_d    = out_st_q;
    rd_addr     = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          item_d   = pop_item_i;
          res_re_d = '0;
          res_im_d = '0;
          res_st_d = ST_BIN_DONE;
          sat_d    = 1'b0;
          state_d  = S_DONE;
          case (pop_item_i.op)
            OP_CLEAR: begin
              count_d  = '0;
              wp_d     = '0;
              res_st_d = ST_CLEARED;
            end
            OP_APPEND: begin
              wp_d = '0;
              if (count_q < DEPTH_C) begin
                count_d  = count_q + CW'(1);
                res_st_d = ST_STORED;
              end else begin
                res_st_d = ST_DROPPED;
              end
            end
            OP_PASS: begin
              wp_d     = '0;
              res_re_d = pop_item_i.re;
              res_im_d = pop_item_i.im;
            end
            OP_BIN: begin
              if (count_q < CW'(2)) begin
                gain_d  = GAIN_ONE;
                state_d = S_SRE;
              end else begin
                state_d = S_CHK0;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHK0: begin
        f0_d    = rd_freq;
        rd_addr = last;
        state_d = S_CHKL;
      end
      S_CHKL: begin
        // Below the first breakpoint, or at or above the last one: unity gain
        if ((f < FREQ_W'(f0_q)) || (f >= FREQ_W'(rd_freq))) begin
          gain_d  = GAIN_ONE;
          state_d = S_SRE;
        end else begin
          j_d     = (wp_q > last) ? last : wp_q;
          rd_addr = j_d;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        // Advance while the breakpoint lies below the bin
        if ((j_q != last) && (f > FREQ_W'(rd_freq))) begin
          j_d     = j_q + AW'(1);
          rd_addr = j_d;
        end else begin
          wp_d = j_q;
          if (j_q == '0) begin
            gain_d  = rd_gain;
            state_d = S_SRE;
          end else begin
            fj_d    = rd_freq;
            gj_d    = rd_gain;
            rd_addr = j_q - AW'(1);
            state_d = S_PREV;
          end
        end
      end
      S_PREV: begin
        // A non-rising span takes the upper gain; else span, clamped offset and gain difference magnitude
        if (fj_q <= rd_freq) begin
          gain_d  = gj_q;
          state_d = S_SRE;
        end else begin
          span_d  = fj_q - rd_freq;
          if (f[31:0] < rd_freq)      off_d = '0;
          else if (fdiff > span_d)    off_d = span_d;
          else                        off_d = fdiff;
          neg_d   = dg[32];
          dmag_d  = dg[32] ? 33'(-dg) : 33'(dg);
          gbase_d = rd_gain;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        quo_d   = 64'(dmag_q * 65'(off_q));
        rem_d   = '0;
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        // One restoring step per cycle
        if (!trial[32]) begin
          rem_d = trial;
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = {rem_q[31:0], quo_q[63]};
          quo_d = {quo_q[62:0], 1'b0};
        end
        step_d = step_q + 6'd1;
        if (step_q == 6'd63) state_d = S_ADD;
      end
      S_ADD: begin
        gain_d  = neg_q ? (gbase_q - $signed(quo_q[31:0]))
                        : (gbase_q + $signed(quo_q[31:0]));
        state_d = S_SRE;
      end
      S_SRE: begin
        prod_d  = 64'(item_q.re) * 64'(gain_q);
        state_d = S_SIM;
      end
      S_SIM: begin
        prod_d   = 64'(item_q.im) * 64'(gain_q);
        res_re_d = rsat;
        sat_d    = rovf;
        state_d  = S_SAT;
      end
      S_SAT: begin
        res_im_d = rsat;
        res_st_d = (sat_q || rovf) ? ST_SATURATED : ST_BIN_DONE;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_re_d    = res_re_q;
          out_im_d    = res_im_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      wp_q        <= '0;
      j_q         <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wp_q        <= wp_d;
      j_q         <= j_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    f0_q     <= f0_d;
    fj_q     <= fj_d;
    gj_q     <= gj_d;
    gbase_q  <= gbase_d;
    span_q   <= span_d;
    off_q    <= off_d;
    dmag_q   <= dmag_d;
    neg_q    <= neg_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    gain_q   <= gain_d;
    prod_q   <= prod_d;
    res_re_q <= res_re_d;
    res_im_q <= res_im_d;
    sat_q    <= sat_d;
    res_st_q <= res_st_d;
    out_re_q <= out_re_d;
    out_im_q <= out_im_d;
    out_st_q <= out_st_d;
  end

  // Table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[count_q[AW-1:0]] <= {pop_item_i.pfreq, pop_item_i.pgain};
    rdata_q <= mem_q[rd_addr];
  end

endmodule

@@ hdl/spectral_gain_interpolator_core.sv @@
// Top level of the spectral gain interpolator: config register, front, queue, back.
// Depends on sgi_pkg, sgi_front, sgi_queue and sgi_back.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    command, bin_index, bin_re/im, point_*
//   out      output     out_valid_o / out_ready_i  out_re, out_im, status
//   cfg      input      cfg_we_i                   cfg_wdata_i (freq_step)
//
// Clear, append, pass and unused commands skip the table walk and the scaling.
// Bins with fewer than two entries, and bins outside the table, get unity gain without a walk.
// Interpolated bins walk the table and then pass through the 64-step serial
// divider in the back end. Exact hits on the first entry and non-rising spans
// walk the table but skip the divide.
// Reset is asynchronous and active low; the table needs no clearing pass.
// The two-entry queue lets input be taken while the back end or output stalls.
module spectral_gain_interpolator_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic [15:0]        bin_index_i,
  input  logic signed [31:0] bin_re_i,
  input  logic signed [31:0] bin_im_i,
  input  logic [31:0]        point_freq_i,
  input  logic signed [31:0] point_gain_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_re_o,
  output logic signed [31:0] out_im_o,
  output logic [2:0]         status_o
);
  import sgi_pkg::*;

  logic [31:0] freq_step_q;
  logic        push_valid, push_ready, pop_valid, pop;
  item_t       push_item, pop_item;

  // Frequency step register, 1.0 Hz after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_step_q <= 32'd65536;
    end else if (cfg_we_i) begin
      freq_step_q <= cfg_wdata_i;
    end
  end

  sgi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .bin_index_i  (bin_index_i),
    .bin_re_i     (bin_re_i),
    .bin_im_i     (bin_im_i),
    .point_freq_i (point_freq_i),
    .point_gain_i (point_gain_i),
    .freq_step_i  (freq_step_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  sgi_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  sgi_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o),
    .status_o    (status_o)
  );

`ifndef ASSERT_OFF
  // Load and clear results carry zero samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_STORED || status_o == ST_DROPPED ||
                    status_o == ST_CLEARED)
    |-> (out_re_o == 32'sd0) && (out_im_o == 32'sd0))
    else $error("load result with nonzero sample");

  // Saturation status only with a clipped component
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_SATURATED)
    |-> (out_re_o == 32'sh7fffffff) || (out_re_o == 32'sh80000000) ||
        (out_im_o == 32'sh7fffffff) || (out_im_o == 32'sh80000000))
    else $error("saturation flagged without clipped output");
`endif

endmodule
